/* design/tfsk_pkg.sv */
// Package for the two-tone FSK bit detector: payload structs, sizes,
// register indexes and the fixed-point biquad coefficient table.
// Used by tfsk_cascade and two_tone_fsk_bit_detector_top.
package tfsk_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int SECTIONS   = 4;
  localparam int WINDOW_LEN = 18;

  // History rows: per filter one row for the input and one per section.
  localparam int ROWS    = 2 * (SECTIONS + 1);
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int WIN_AW  = $clog2(WINDOW_LEN);
  localparam int COEF_W  = FRAC_BITS + 3;
  localparam int S_W     = 35;
  localparam int PROD_W  = COEF_W + S_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam longint DecScale = 64'sd100000000;

  localparam logic [1:0] COEF_G  = 2'd0;
  localparam logic [1:0] COEF_A1 = 2'd1;
  localparam logic [1:0] COEF_A2 = 2'd2;

  localparam logic [2:0] CFG_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_FRAME_BITS  = 3'd1;
  localparam logic [2:0] CFG_FIRST_TICKS = 3'd2;
  localparam logic [2:0] CFG_BIT_TICKS   = 3'd3;
  localparam logic [2:0] CFG_NOISE_LIMIT = 3'd4;

  typedef struct packed {
    logic               command;
    logic signed [15:0] sample_value;
  } tfsk_in_t;

  typedef struct packed {
    logic              bit_valid;
    logic              bit_value;
    logic signed [7:0] bit_score;
    logic              tone_zero_seen;
    logic              tone_one_seen;
    logic              listening_now;
    logic              fluke_flag;
    logic              frame_done;
  } tfsk_out_t;

  // Result of one pass of both cascades.
  typedef struct packed {
    logic        done;
    logic        idle;
    logic [31:0] y0;
    logic [31:0] y1;
  } tfsk_casc_t;

  // Coefficient in units of 1e-8, truncated toward zero at FRAC_BITS.
  function automatic logic signed [COEF_W-1:0] coef_q(input logic f,
                                                      input logic [1:0] k,
                                                      input logic [1:0] sel);
    longint raw;
    raw = 64'sd0;
    unique case ({f, sel, k})
      {1'b0, COEF_G,  2'd0}: raw = 64'sd201900;
      {1'b0, COEF_G,  2'd1}: raw = 64'sd196400;
      {1'b0, COEF_G,  2'd2}: raw = 64'sd2280000;
      {1'b0, COEF_G,  2'd3}: raw = 64'sd2294000;
      {1'b1, COEF_G,  2'd0}: raw = 64'sd303500;
      {1'b1, COEF_G,  2'd1}: raw = 64'sd295500;
      {1'b1, COEF_G,  2'd2}: raw = 64'sd2263000;
      {1'b1, COEF_G,  2'd3}: raw = 64'sd2271000;
      {1'b0, COEF_A1, 2'd0}: raw = -64'sd184602348;
      {1'b0, COEF_A1, 2'd1}: raw = -64'sd184997046;
      {1'b0, COEF_A1, 2'd2}: raw = -64'sd185002393;
      {1'b0, COEF_A1, 2'd3}: raw = -64'sd185937390;
      {1'b1, COEF_A1, 2'd0}: raw = -64'sd177495574;
      {1'b1, COEF_A1, 2'd1}: raw = -64'sd178072480;
      {1'b1, COEF_A1, 2'd2}: raw = -64'sd177882789;
      {1'b1, COEF_A1, 2'd3}: raw = -64'sd179257281;
      {1'b0, COEF_A2, 2'd0}: raw = 64'sd98747166;
      {1'b0, COEF_A2, 2'd1}: raw = 64'sd98763379;
      {1'b0, COEF_A2, 2'd2}: raw = 64'sd99474384;
      {1'b0, COEF_A2, 2'd3}: raw = 64'sd99490711;
      {1'b1, COEF_A2, 2'd0}: raw = 64'sd98471132;
      {1'b1, COEF_A2, 2'd1}: raw = 64'sd98490396;
      {1'b1, COEF_A2, 2'd2}: raw = 64'sd99358215;
      {1'b1, COEF_A2, 2'd3}: raw = 64'sd99377646;
      default:               raw = 64'sd0;
    endcase
    return COEF_W'((raw * (64'sd1 <<< FRAC_BITS)) / DecScale);
  endfunction

endpackage

/* design/two_tone_fsk_bit_detector_top.sv */
// Top level of the two-tone FSK bit detector: handshakes, configuration,
// peak window memory, tick scan and bit decision. Uses tfsk_pkg, tfsk_cascade.
//
//   channel | direction | payload    | transfer when
//   in_     | input     | tfsk_in_t  | in_valid && !in_stall
//   out_    | output    | tfsk_out_t | out_valid && !out_stall
//   cfg_    | input     | 20-bit reg | cfg_wr_en
//
// A sample is run through both cascades on the shared multiplier, which does
// three products per biquad section.
// A tick scans every slot of the window memory for the peaks, then may
// wait for the output register to drain.
// Out-of-range samples are taken and dropped.
// Reset is synchronous; no clearing pass is needed after it.
module two_tone_fsk_bit_detector_top import tfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tfsk_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tfsk_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_FILT = 3'd1;
  localparam logic [2:0] T_SCAN = 3'd2;
  localparam logic [2:0] T_LAST = 3'd3;
  localparam logic [2:0] T_DEC  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [19:0]       thr_r;
  logic [7:0]        frame_bits_r;
  logic [6:0]        first_ticks_r, bit_ticks_r;
  logic [4:0]        noise_limit_r;

  logic [6:0]        tick_r, tick_nxt;
  logic [7:0]        bits_r, bits_nxt;
  logic [7:0]        score_r, score_nxt;
  logic              listen_r, listen_nxt;
  logic [4:0]        silent_r, silent_nxt;

  logic [63:0]           win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_vld_r;
  logic [WIN_AW-1:0]     slot_r, scan_r;
  logic [63:0]           win_rd_r;
  logic                  win_rvld_r, pend_r;
  logic [63:0]           win_q;
  logic signed [31:0]    peak0_r, peak1_r, cand0, cand1;

  logic        accept, start, clr, out_load, t0, t1;
  logic        fl, done_f, val, bval;
  logic [7:0]  scv;
  tfsk_casc_t  casc;
  tfsk_out_t   out_r;
  logic        out_valid_r;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != T_IDLE);
  assign start    = accept && !in_data.command && (in_data.sample_value[15:12] == 4'd0);
  assign out_load = (state_r == T_DEC) && (!out_valid_r || !out_stall);
  assign clr      = out_load && (val || fl || done_f);

  tfsk_cascade u_cascade (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_data.sample_value[11:0]),
    .clr    (clr),
    .res    (casc)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (accept && in_data.command) begin
          state_nxt = T_SCAN;
        end else if (start) begin
          state_nxt = T_FILT;
        end
      end
      T_FILT: if (casc.done) state_nxt = T_IDLE;
      T_SCAN: if (scan_r == WIN_AW'(WINDOW_LEN - 1)) state_nxt = T_LAST;
      T_LAST: state_nxt = T_DEC;
      T_DEC:  if (out_load) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // Window memory: one write per sample, one read per scan cycle.
  assign win_q = win_rvld_r ? win_rd_r : 64'd0;
  assign cand0 = win_q[63:32];
  assign cand1 = win_q[31:0];

  always_ff @(posedge clk) begin
    if (state_r == T_FILT && casc.done) begin
      win_mem[slot_r] <= {casc.y0, casc.y1};
    end
    win_rd_r   <= win_mem[scan_r];
    win_rvld_r <= win_vld_r[scan_r];
  end

  assign t0 = peak0_r > $signed({12'd0, thr_r});
  assign t1 = peak1_r > $signed({12'd0, thr_r});

  // Bit decision for the tick, in the order the scoring rules apply.
  always_comb begin
    tick_nxt   = tick_r;
    bits_nxt   = bits_r;
    score_nxt  = score_r;
    listen_nxt = listen_r;
    silent_nxt = silent_r;
    fl         = 1'b0;
    val        = 1'b0;
    scv        = 8'd0;
    done_f     = 1'b0;
    if (t0 || t1) begin
      if (tick_nxt == 7'd0) begin
        bits_nxt   = 8'd0;
        score_nxt  = 8'd0;
        listen_nxt = 1'b1;
        silent_nxt = 5'd0;
      end
      score_nxt = score_nxt + 8'(t1) - 8'(t0);
    end
    if (listen_nxt && bits_nxt == 8'd0 && tick_nxt < first_ticks_r && !t0 && !t1) begin
      silent_nxt = silent_nxt + 5'd1;
      if (silent_nxt > noise_limit_r) begin
        tick_nxt   = 7'd0;
        bits_nxt   = 8'd0;
        score_nxt  = 8'd0;
        listen_nxt = 1'b0;
        silent_nxt = 5'd0;
        fl         = 1'b1;
      end
    end
    if (tick_nxt == 7'(bit_ticks_r - 7'd1) ||
        (bits_nxt == 8'd0 && tick_nxt == 7'(first_ticks_r - 7'd1))) begin
      bits_nxt  = bits_nxt + 8'd1;
      tick_nxt  = 7'd0;
      val       = 1'b1;
      scv       = score_nxt;
      score_nxt = 8'd0;
    end
    if (bits_nxt == frame_bits_r) begin
      tick_nxt   = 7'd0;
      bits_nxt   = 8'd0;
      score_nxt  = 8'd0;
      listen_nxt = 1'b0;
      done_f     = 1'b1;
    end
    if (listen_nxt) begin
      tick_nxt = tick_nxt + 7'd1;
    end
    bval = (scv != 8'd0) && !scv[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      thr_r         <= 20'd100;
      frame_bits_r  <= 8'd8;
      first_ticks_r <= 7'd75;
      bit_ticks_r   <= 7'd100;
      noise_limit_r <= 5'd15;
      tick_r        <= '0;
      bits_r        <= '0;
      score_r       <= '0;
      listen_r      <= 1'b0;
      silent_r      <= '0;
      win_vld_r     <= '0;
      slot_r        <= '0;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_THRESHOLD:   thr_r         <= cfg_wdata;
          CFG_FRAME_BITS:  frame_bits_r  <= cfg_wdata[7:0];
          CFG_FIRST_TICKS: first_ticks_r <= cfg_wdata[6:0];
          CFG_BIT_TICKS:   bit_ticks_r   <= cfg_wdata[6:0];
          CFG_NOISE_LIMIT: noise_limit_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (state_r == T_FILT && casc.done) begin
        win_vld_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == WIN_AW'(WINDOW_LEN - 1)) ? '0 : slot_r + WIN_AW'(1);
      end else if (clr) begin
        win_vld_r <= '0;
      end
      pend_r <= (state_r == T_SCAN);
      if (out_load) begin
        tick_r      <= tick_nxt;
        bits_r      <= bits_nxt;
        score_r     <= score_nxt;
        listen_r    <= listen_nxt;
        silent_r    <= silent_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_IDLE) begin
      scan_r  <= '0;
      peak0_r <= '0;
      peak1_r <= '0;
    end else begin
      if (state_r == T_SCAN) begin
        scan_r <= scan_r + WIN_AW'(1);
      end
      if (pend_r) begin
        if (cand0 > peak0_r) peak0_r <= cand0;
        if (cand1 > peak1_r) peak1_r <= cand1;
      end
    end
    if (out_load) begin
      out_r.bit_valid      <= val;
      out_r.bit_value      <= bval;
      out_r.bit_score      <= scv;
      out_r.tone_zero_seen <= t0;
      out_r.tone_one_seen  <= t1;
      out_r.listening_now  <= listen_nxt;
      out_r.fluke_flag     <= fl;
      out_r.frame_done     <= done_f;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The cascade only runs while a sample transaction is in flight.
  a_casc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != T_FILT) |-> casc.idle) else $error("cascade busy outside sample");

  a_out_from_dec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_DEC)) else $error("result without tick");

  a_clr_only_dec: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (win_vld_r == '0)) else $error("window not cleared");

endmodule

/* design/tfsk_cascade.sv */
// Both biquad cascades, run one section at a time through a shared multiplier.
// Section history lives in a one-port-read, one-port-write memory. Uses tfsk_pkg.
module tfsk_cascade import tfsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] sample,
  input  logic        clr,
  output tfsk_casc_t  res
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_L0   = 3'd1;
  localparam logic [2:0] C_SEC  = 3'd2;
  localparam logic [2:0] C_M1   = 3'd3;
  localparam logic [2:0] C_M2   = 3'd4;
  localparam logic [2:0] C_M3   = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic                      f_r, f_nxt;
  logic [SEC_W-1:0]          k_r, k_nxt;
  logic [11:0]               x_r, x_nxt;
  logic signed [31:0]        in0_r, in0_nxt, in1_r, in1_nxt, in2_r, in2_nxt;
  logic signed [31:0]        y1_r, y1_nxt, y2_r, y2_nxt;
  logic [31:0]               y0_r, y0_nxt;
  logic signed [PROD_W-1:0]  p_r, p_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, acc_fin;
  logic                      done_r, done_nxt;
  logic [31:0]               y_res_r, y_res_nxt;

  logic [63:0]               mem [ROWS];
  logic [ROWS-1:0]           row_vld_r;
  logic [63:0]               rd_data_r;
  logic                      rd_vld_r;
  logic [ROW_AW-1:0]         rd_addr, wr_addr;
  logic                      wr_en;
  logic [63:0]               wr_data, hist;

  logic signed [COEF_W-1:0]  mul_a;
  logic signed [S_W-1:0]     mul_b, s_sum;
  logic [1:0]                k2;
  logic [31:0]               y_new;

  function automatic logic [ROW_AW-1:0] row_addr(input logic f, input logic [2:0] lvl);
    return ROW_AW'(f ? (SECTIONS + 1) : 0) + ROW_AW'(lvl);
  endfunction

  assign hist    = rd_vld_r ? rd_data_r : 64'd0;
  assign k2      = 2'(k_r);
  assign acc_fin = acc_r - ACC_W'(p_r);
  assign y_new   = acc_fin[FRAC_BITS+31:FRAC_BITS];

  always_comb begin
    if (k_r < SEC_W'(2)) begin
      s_sum = S_W'(in0_r) + (S_W'(in1_r) <<< 1) + S_W'(in2_r);
    end else begin
      s_sum = S_W'(in0_r) - (S_W'(in1_r) <<< 1) + S_W'(in2_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    in0_nxt   = in0_r;
    in1_nxt   = in1_r;
    in2_nxt   = in2_r;
    y1_nxt    = y1_r;
    y2_nxt    = y2_r;
    y0_nxt    = y0_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    y_res_nxt = y_res_r;
    rd_addr   = row_addr(f_r, 3'd0);
    wr_en     = 1'b0;
    wr_addr   = row_addr(f_r, 3'd0);
    wr_data   = 64'd0;
    mul_a     = coef_q(f_r, k2, COEF_G);
    mul_b     = s_sum;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          x_nxt     = sample;
          f_nxt     = 1'b0;
          rd_addr   = row_addr(1'b0, 3'd0);
          state_nxt = C_L0;
        end
      end
      C_L0: begin
        in0_nxt   = 32'(signed'({1'b0, x_r}));
        in1_nxt   = hist[63:32];
        in2_nxt   = hist[31:0];
        wr_en     = 1'b1;
        wr_addr   = row_addr(f_r, 3'd0);
        wr_data   = {20'd0, x_r, hist[63:32]};
        k_nxt     = '0;
        rd_addr   = row_addr(f_r, 3'd1);
        state_nxt = C_SEC;
      end
      C_SEC: begin
        y1_nxt    = hist[63:32];
        y2_nxt    = hist[31:0];
        state_nxt = C_M1;
      end
      C_M1: begin
        acc_nxt   = ACC_W'(p_r);
        mul_a     = coef_q(f_r, k2, COEF_A1);
        mul_b     = S_W'(y1_r);
        state_nxt = C_M2;
      end
      C_M2: begin
        acc_nxt   = acc_r - ACC_W'(p_r);
        mul_a     = coef_q(f_r, k2, COEF_A2);
        mul_b     = S_W'(y2_r);
        state_nxt = C_M3;
      end
      C_M3: begin
        wr_en   = 1'b1;
        wr_addr = row_addr(f_r, 3'(k_r) + 3'd1);
        wr_data = {y_new, y1_r};
        in0_nxt = y_new;
        in1_nxt = y1_r;
        in2_nxt = y2_r;
        if (k_r != SEC_W'(SECTIONS - 1)) begin
          k_nxt     = k_r + SEC_W'(1);
          rd_addr   = row_addr(f_r, 3'(k_r) + 3'd2);
          state_nxt = C_SEC;
        end else if (!f_r) begin
          y0_nxt    = y_new;
          f_nxt     = 1'b1;
          rd_addr   = row_addr(1'b1, 3'd0);
          state_nxt = C_L0;
        end else begin
          done_nxt  = 1'b1;
          y_res_nxt = y_new;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
    p_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_IDLE;
      done_r    <= 1'b0;
      row_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (clr) begin
        row_vld_r <= '0;
      end else if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    f_r     <= f_nxt;
    k_r     <= k_nxt;
    x_r     <= x_nxt;
    in0_r   <= in0_nxt;
    in1_r   <= in1_nxt;
    in2_r   <= in2_nxt;
    y1_r    <= y1_nxt;
    y2_r    <= y2_nxt;
    y0_r    <= y0_nxt;
    p_r     <= p_nxt;
    acc_r   <= acc_nxt;
    y_res_r <= y_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= row_vld_r[rd_addr];
  end

  assign res.done = done_r;
  assign res.idle = (state_r == C_IDLE);
  assign res.y0   = y0_r;
  assign res.y1   = y_res_r;

  // A write never targets the row being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr != rd_addr)) else $error("history read/write clash");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == C_IDLE)) else $error("done while busy");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == C_IDLE) |=> (state_r == C_L0 && !f_r))
    else $error("cascade did not start on the first filter");

endmodule

/* tb/two_tone_fsk_bit_detector_top_tb.sv */
// Self-checking testbench for two_tone_fsk_bit_detector_top: a cycle-free
// model of the biquad cascades, window peaks and bit scoring predicts every tick.
// Depends on tfsk_pkg and the top level of the design.
module two_tone_fsk_bit_detector_top_tb;
  import tfsk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 600000;

  // Filter coefficients in units of 1e-8, per tone and section.
  localparam longint GAIN_E8 [2][4] = '{'{201900, 196400, 2280000, 2294000},
                                        '{303500, 295500, 2263000, 2271000}};
  localparam longint A1_E8 [2][4] = '{'{-184602348, -184997046, -185002393, -185937390},
                                      '{-177495574, -178072480, -177882789, -179257281}};
  localparam longint A2_E8 [2][4] = '{'{98747166, 98763379, 99474384, 99490711},
                                      '{98471132, 98490396, 99358215, 99377646}};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tfsk_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  tfsk_out_t   out_data;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_wdata;

  two_tone_fsk_bit_detector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Detector model state.
  longint      gain_q [2][4];
  longint      a1_q [2][4];
  longint      a2_q [2][4];
  logic [31:0] filt_hist [2][SECTIONS+1][2];
  logic [31:0] peak_ring [2][WINDOW_LEN];
  int          ring_pos;
  logic [6:0]  tick_cnt;
  logic [7:0]  bit_cnt;
  logic [7:0]  score_acc;
  logic        in_frame;
  logic [4:0]  quiet_ticks;
  logic [19:0] thr_reg;
  logic [7:0]  frame_len_reg;
  logic [6:0]  first_len_reg;
  logic [6:0]  bit_len_reg;
  logic [4:0]  noise_reg;

  tfsk_out_t   pending_ticks [$];
  int          errors;
  int          cycle_cnt;
  int          hold_off;
  int          burst_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic void clear_filters();
    for (int f = 0; f < 2; f++) begin
      for (int r = 0; r <= SECTIONS; r++) begin
        filt_hist[f][r][0] = '0;
        filt_hist[f][r][1] = '0;
      end
      for (int i = 0; i < WINDOW_LEN; i++) peak_ring[f][i] = '0;
    end
  endfunction

  function automatic logic [31:0] run_biquads(int f, longint x);
    longint      i0, i1, i2, s, y1, y2, acc;
    logic [31:0] yw;
    i0 = x;
    i1 = sext32(filt_hist[f][0][0]);
    i2 = sext32(filt_hist[f][0][1]);
    yw = x[31:0];
    filt_hist[f][0][1] = filt_hist[f][0][0];
    filt_hist[f][0][0] = yw;
    for (int k = 0; k < SECTIONS; k++) begin
      s = (k < 2) ? i0 + 2 * i1 + i2 : i0 - 2 * i1 + i2;
      y1 = sext32(filt_hist[f][k+1][0]);
      y2 = sext32(filt_hist[f][k+1][1]);
      acc = gain_q[f][k] * s - a1_q[f][k] * y1 - a2_q[f][k] * y2;
      acc = acc >>> FRAC_BITS;
      yw = acc[31:0];
      filt_hist[f][k+1][1] = filt_hist[f][k+1][0];
      filt_hist[f][k+1][0] = yw;
      i0 = sext32(yw);
      i1 = y1;
      i2 = y2;
    end
    return yw;
  endfunction

  function automatic logic tone_present(int f);
    longint pk;
    pk = 0;
    for (int i = 0; i < WINDOW_LEN; i++)
      if (sext32(peak_ring[f][i]) > pk) pk = sext32(peak_ring[f][i]);
    return pk > longint'(thr_reg);
  endfunction

  // Advances the model by one accepted transaction and queues the tick result.
  function automatic void predict_detector(tfsk_in_t it);
    tfsk_out_t   r;
    logic [31:0] y0, y1;
    logic        t0, t1;
    if (it.command == 1'b0) begin
      if (it.sample_value < 0 || it.sample_value > 4095) return;
      y0 = run_biquads(0, longint'(it.sample_value));
      y1 = run_biquads(1, longint'(it.sample_value));
      if (ring_pos >= WINDOW_LEN) ring_pos = 0;
      peak_ring[0][ring_pos] = y0;
      peak_ring[1][ring_pos] = y1;
      ring_pos = (ring_pos + 1 >= WINDOW_LEN) ? 0 : ring_pos + 1;
      return;
    end
    r = '0;
    t0 = tone_present(0);
    t1 = tone_present(1);
    if (t0 || t1) begin
      if (tick_cnt == 0) begin
        bit_cnt = '0;
        score_acc = '0;
        in_frame = 1'b1;
        quiet_ticks = '0;
      end
      score_acc = score_acc + {7'd0, t1} - {7'd0, t0};
    end
    if (in_frame && bit_cnt == 0 && tick_cnt < first_len_reg && !t0 && !t1) begin
      quiet_ticks = quiet_ticks + 5'd1;
      if (quiet_ticks > noise_reg) begin
        tick_cnt = '0;
        bit_cnt = '0;
        score_acc = '0;
        in_frame = 1'b0;
        quiet_ticks = '0;
        clear_filters();
        r.fluke_flag = 1'b1;
      end
    end
    if (tick_cnt == bit_len_reg - 7'd1 ||
        (bit_cnt == 0 && tick_cnt == first_len_reg - 7'd1)) begin
      bit_cnt = bit_cnt + 8'd1;
      tick_cnt = '0;
      r.bit_valid = 1'b1;
      r.bit_score = score_acc;
      r.bit_value = (score_acc != 0 && !score_acc[7]);
      clear_filters();
      score_acc = '0;
    end
    if (bit_cnt == frame_len_reg) begin
      tick_cnt = '0;
      bit_cnt = '0;
      score_acc = '0;
      in_frame = 1'b0;
      clear_filters();
      r.frame_done = 1'b1;
    end
    if (in_frame) tick_cnt = tick_cnt + 7'd1;
    r.tone_zero_seen = t0;
    r.tone_one_seen = t1;
    r.listening_now = in_frame;
    pending_ticks.push_back(r);
  endfunction

  // Receiver: stalls in changing patterns, or holds off for a counted stretch.
  always @(posedge clk) begin
    tfsk_out_t e;
    int        mode;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        $error("tick result with nothing expected");
        errors++;
      end else begin
        e = pending_ticks.pop_front();
        if (out_data.bit_valid !== e.bit_valid) begin
          $error("bit_valid exp %0d got %0d", e.bit_valid, out_data.bit_valid); errors++;
        end
        if (out_data.bit_value !== e.bit_value) begin
          $error("bit_value exp %0d got %0d", e.bit_value, out_data.bit_value); errors++;
        end
        if (out_data.bit_score !== e.bit_score) begin
          $error("bit_score exp %0d got %0d", e.bit_score, out_data.bit_score); errors++;
        end
        if (out_data.tone_zero_seen !== e.tone_zero_seen) begin
          $error("tone_zero_seen exp %0d got %0d", e.tone_zero_seen,
                 out_data.tone_zero_seen); errors++;
        end
        if (out_data.tone_one_seen !== e.tone_one_seen) begin
          $error("tone_one_seen exp %0d got %0d", e.tone_one_seen,
                 out_data.tone_one_seen); errors++;
        end
        if (out_data.listening_now !== e.listening_now) begin
          $error("listening_now exp %0d got %0d", e.listening_now,
                 out_data.listening_now); errors++;
        end
        if (out_data.fluke_flag !== e.fluke_flag) begin
          $error("fluke_flag exp %0d got %0d", e.fluke_flag, out_data.fluke_flag); errors++;
        end
        if (out_data.frame_done !== e.frame_done) begin
          $error("frame_done exp %0d got %0d", e.frame_done, out_data.frame_done); errors++;
        end
      end
    end
    mode = (cycle_cnt / 97) % 4;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else if (mode == 2) out_stall <= (cycle_cnt % 5 < 2);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offers one transaction and holds it until the block takes it.
  task automatic send_item(tfsk_in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_detector(it);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic paced_send(tfsk_in_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_THRESHOLD:   thr_reg = val;
      CFG_FRAME_BITS:  frame_len_reg = val[7:0];
      CFG_FIRST_TICKS: first_len_reg = val[6:0];
      CFG_BIT_TICKS:   bit_len_reg = val[6:0];
      CFG_NOISE_LIMIT: noise_reg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [19:0] thr, logic [7:0] frame_len, logic [6:0] first_len,
                           logic [6:0] bit_len, logic [4:0] noise);
    wait_quiet();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_FRAME_BITS, {12'd0, frame_len});
    write_reg(CFG_FIRST_TICKS, {13'd0, first_len});
    write_reg(CFG_BIT_TICKS, {13'd0, bit_len});
    write_reg(CFG_NOISE_LIMIT, {15'd0, noise});
  endtask

  function automatic tfsk_in_t make_item(logic cmd, logic signed [15:0] v);
    tfsk_in_t it;
    it.command = cmd;
    it.sample_value = v;
    return it;
  endfunction

  // Runs of in-range random samples closed by a tick, plus near-constant silence and noise.
  task automatic run_traffic(int n_items);
    int kind, len;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if (kind < 5)
          paced_send(make_item(1'b0, 16'($urandom_range(0, 4095))));
        else if (kind < 8)
          paced_send(make_item(1'b0, 16'(2048 + $urandom_range(0, 3))));
        else
          paced_send(make_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
        sent++;
      end
      paced_send(make_item(1'b1, 16'($urandom_range(0, 65535))));
      sent++;
    end
  endtask

  task automatic test_directed();
    logic signed [15:0] edge_vals [8] = '{16'sd0, 16'sd4095, 16'sd4096, -16'sd1,
                                          16'sd32767, -16'sd32768, 16'sd2048, 16'sd1};
    configure(20'd0, 8'd2, 7'd2, 7'd3, 5'd1);
    foreach (edge_vals[i]) send_item(make_item(1'b0, edge_vals[i]));
    for (int i = 0; i < 6; i++) send_item(make_item(1'b1, 16'sd0));
    // Ticks with no samples seen since the last decision are silent.
    for (int i = 0; i < 6; i++) send_item(make_item(1'b1, -16'sd1));
  endtask

  task automatic test_settings_sweep();
    configure(20'd100, 8'd8, 7'd75, 7'd100, 5'd15);
    run_traffic(60);
    configure(20'd50, 8'd8, 7'd4, 7'd6, 5'd2);
    run_traffic(90);
    configure(20'd0, 8'd1, 7'd1, 7'd1, 5'd0);
    run_traffic(70);
    configure(20'd1048575, 8'd255, 7'd127, 7'd127, 5'd31);
    run_traffic(60);
    configure(20'd20, 8'd255, 7'd1, 7'd3, 5'd31);
    run_traffic(80);
    configure(20'd200, 8'd3, 7'd10, 7'd5, 5'd0);
    run_traffic(90);
    configure(20'd10, 8'd4, 7'd127, 7'd1, 5'd5);
    run_traffic(70);
    configure(20'($urandom_range(0, 500)), 8'($urandom_range(1, 6)),
              7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)), 5'($urandom_range(0, 4)));
    run_traffic(90);
  endtask

  // The receiver holds off while ticks keep coming, so the input stalls.
  task automatic test_backpressure();
    configure(20'd30, 8'd5, 7'd3, 7'd4, 5'd1);
    hold_off = 1500;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) send_item(make_item(1'b0, 16'($urandom_range(0, 4095))));
      send_item(make_item(1'b1, 16'sd0));
    end
    wait_quiet();
    run_traffic(50);
  endtask

  initial begin
    for (int f = 0; f < 2; f++)
      for (int k = 0; k < 4; k++) begin
        gain_q[f][k] = (GAIN_E8[f][k] * 64'sd16384) / 64'sd100000000;
        a1_q[f][k] = (A1_E8[f][k] * 64'sd16384) / 64'sd100000000;
        a2_q[f][k] = (A2_E8[f][k] * 64'sd16384) / 64'sd100000000;
      end
    clear_filters();
    ring_pos = 0;
    tick_cnt = '0;
    bit_cnt = '0;
    score_acc = '0;
    in_frame = 1'b0;
    quiet_ticks = '0;
    thr_reg = 20'd100;
    frame_len_reg = 8'd8;
    first_len_reg = 7'd75;
    bit_len_reg = 7'd100;
    noise_reg = 5'd15;
    errors = 0;
    cycle_cnt = 0;
    hold_off = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_settings_sweep();
    test_backpressure();

    wait_quiet();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
